// ----- sv/bcm_pkg.sv -----
// Package: shared types, constants and register codes for the binary cross morphology block.
package bcm_pkg;

	// Default row store row length in pixels (maximum frame width)
	localparam int unsigned MAX_WIDTH_DEFAULT = 2048;

	// Configuration port geometry
	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CFG_DATA_W  = 16;
	localparam int unsigned FRAME_WIDTH_W  = 12;
	localparam int unsigned FRAME_HEIGHT_W = 16;

	// Register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_MODE   = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_WIDTH  = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_HEIGHT = 2'd2;

	// Register reset values
	localparam logic [FRAME_WIDTH_W-1:0]  WIDTH_RESET  = 12'd640;
	localparam logic [FRAME_HEIGHT_W-1:0] HEIGHT_RESET = 16'd480;

	// Item opcodes
	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	// Command queue between front and back
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

	typedef enum logic [1:0] {
		MODE_ERODE     = 2'd0,
		MODE_DILATE    = 2'd1,
		MODE_DESPECKLE = 2'd2,
		MODE_HOLE_FILL = 2'd3
	} morph_mode_t;

	// Input item
	typedef struct packed {
		logic       op;
		logic [7:0] pixel_value;
	} item_t;

	// Result item
	typedef struct packed {
		logic result_pixel;
		logic frame_end;
	} result_t;

	// Classified command handed from front to back (column travels beside it)
	typedef struct packed {
		logic emit;       // produces a result
		logic write;      // stores pix into the row store
		logic cpar;       // row parity of the window center row
		logic upar;       // row parity of the up neighbor row
		logic up_is_c;    // top edge: up clamps to center
		logic down_is_c;  // drain: down clamps to center
		logic l_use_c;    // left edge
		logic r_use_c;    // right edge
		logic pix;        // incoming pixel, nonzero test done
		logic frame_end;  // last result of the frame
	} cmd_flags_t;

endpackage

// ----- sv/bcm_front.sv -----
// Front end: accepts items, tracks raster position and classifies each item into a command.
module bcm_front #(
	parameter int unsigned MAX_WIDTH = bcm_pkg::MAX_WIDTH_DEFAULT
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 item_valid,
	input  bcm_pkg::item_t                       item,
	input  logic [bcm_pkg::FRAME_WIDTH_W-1:0]    frame_width,
	input  logic [bcm_pkg::FRAME_HEIGHT_W-1:0]   frame_height,
	input  logic                                 q_full,
	output logic                                 push,
	output bcm_pkg::cmd_flags_t                  push_flags,
	output logic [$clog2(MAX_WIDTH)-1:0]         push_col
);
	import bcm_pkg::*;

	localparam int unsigned COL_W  = $clog2(MAX_WIDTH);
	localparam int unsigned PEND_W = $clog2(MAX_WIDTH + 1);

	logic [COL_W-1:0]          col_cnt_q;
	logic [FRAME_HEIGHT_W-1:0] row_cnt_q;
	logic [PEND_W-1:0]         pend_q;

	logic [COL_W-1:0]          wm1;
	logic [FRAME_HEIGHT_W-1:0] hm1;
	logic [COL_W-1:0]          col;
	logic                      last_col;
	logic                      draining;
	logic                      is_flush;
	logic                      do_flush;
	logic                      do_pixel;
	logic                      accept;

	// Effective geometry: width clamped to 1..MAX_WIDTH, height at least 1
	always_comb begin
		if (frame_width == '0) begin
			wm1 = '0;
		end else if (32'(frame_width) > MAX_WIDTH) begin
			wm1 = COL_W'(MAX_WIDTH - 1);
		end else begin
			wm1 = COL_W'(frame_width - 12'd1);
		end
		hm1 = (frame_height == '0) ? '0 : frame_height - 16'd1;
	end

	// Classification
	assign col      = (col_cnt_q > wm1) ? wm1 : col_cnt_q;
	assign last_col = (col == wm1);
	assign draining = (pend_q != '0);
	assign is_flush = (item.op == OP_FLUSH);
	assign do_flush = draining && is_flush;
	assign do_pixel = !draining && !is_flush;
	assign accept   = item_valid && !q_full;
	assign push     = accept && (do_flush || do_pixel);
	assign push_col = col;

	// Window description for the back end
	always_comb begin
		push_flags.emit      = do_flush || (row_cnt_q != '0);
		push_flags.write     = do_pixel;
		push_flags.cpar      = do_flush ? row_cnt_q[0] : ~row_cnt_q[0];
		push_flags.upar      = do_flush ? ~row_cnt_q[0] : row_cnt_q[0];
		push_flags.up_is_c   = do_flush ? (row_cnt_q == '0) : (row_cnt_q == 16'd1);
		push_flags.down_is_c = do_flush;
		push_flags.l_use_c   = (col == '0);
		push_flags.r_use_c   = last_col;
		push_flags.pix       = |item.pixel_value;
		push_flags.frame_end = do_flush && (pend_q == PEND_W'(1));
	end

	// Raster position and drain counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_cnt_q <= '0;
			row_cnt_q <= '0;
			pend_q    <= '0;
		end else if (accept && do_flush) begin
			pend_q <= pend_q - PEND_W'(1);
			if (pend_q == PEND_W'(1)) begin
				row_cnt_q <= '0;
				col_cnt_q <= '0;
			end else begin
				col_cnt_q <= col_cnt_q + COL_W'(1);
			end
		end else if (accept && do_pixel) begin
			if (last_col) begin
				col_cnt_q <= '0;
				if (row_cnt_q >= hm1) begin
					pend_q <= PEND_W'(wm1) + PEND_W'(1);
				end else begin
					row_cnt_q <= row_cnt_q + 16'd1;
				end
			end else begin
				col_cnt_q <= col + COL_W'(1);
			end
		end
	end

endmodule

// ----- sv/bcm_queue.sv -----
// Command queue: short FIFO decoupling the front end from the back end.
module bcm_queue #(
	parameter int unsigned MAX_WIDTH = bcm_pkg::MAX_WIDTH_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  bcm_pkg::cmd_flags_t           push_flags,
	input  logic [$clog2(MAX_WIDTH)-1:0]  push_col,
	input  logic                          pop,
	output bcm_pkg::cmd_flags_t           head_flags,
	output logic [$clog2(MAX_WIDTH)-1:0]  head_col,
	output logic                          not_empty,
	output logic                          full
);
	import bcm_pkg::*;

	localparam int unsigned COL_W = $clog2(MAX_WIDTH);

	cmd_flags_t             flags_q [QUEUE_DEPTH];
	logic [COL_W-1:0]       col_q   [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_PTR_W:0]   count_q;

	assign head_flags = flags_q[rd_ptr_q];
	assign head_col   = col_q[rd_ptr_q];
	assign not_empty  = (count_q != '0);
	assign full       = (count_q == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			flags_q[wr_ptr_q] <= push_flags;
			col_q[wr_ptr_q]   <= push_col;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_PTR_W'(1);
			end
			unique case ({push, pop})
				2'b10: begin
					count_q <= count_q + (QUEUE_PTR_W+1)'(1);
				end
				2'b01: begin
					count_q <= count_q - (QUEUE_PTR_W+1)'(1);
				end
				default: begin
					count_q <= count_q;
				end
			endcase
		end
	end

endmodule

// ----- sv/bcm_back.sv -----
// Back end: row store banks, window evaluation and the result output register.
module bcm_back #(
	parameter int unsigned MAX_WIDTH = bcm_pkg::MAX_WIDTH_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bcm_pkg::morph_mode_t          mode,
	input  logic                          q_valid,
	input  bcm_pkg::cmd_flags_t           q_flags,
	input  logic [$clog2(MAX_WIDTH)-1:0]  q_col,
	output logic                          pop,
	output logic                          result_valid,
	input  logic                          result_stall,
	output bcm_pkg::result_t              result
);
	import bcm_pkg::*;

	localparam int unsigned COL_W      = $clog2(MAX_WIDTH);
	localparam int unsigned BANK_DEPTH = 2 ** COL_W;

	// Read stage
	logic       valid_s1;
	cmd_flags_t flags_s1;
	logic       col0_s1;
	logic       rda_s1 [2];
	logic       rdb_s1 [2];

	// Output stage
	logic    res_valid_s2;
	result_t res_s2;

	logic             out_free;
	logic             s1_go;
	logic             s1_free;
	logic [COL_W-1:0] lcol;
	logic [COL_W-1:0] rcol;
	logic [COL_W-1:0] caddr;
	logic [COL_W-1:0] uaddr;
	logic [COL_W-1:0] laddr;
	logic [COL_W-1:0] raddr;
	logic [COL_W-1:0] waddr;
	logic [COL_W-1:0] addr_a [2];
	logic [COL_W-1:0] addr_b [2];
	logic             we     [2];

	logic w_c;
	logic w_l;
	logic w_r;
	logic w_up;
	logic w_down;
	logic w_res;

	// Stage flow
	assign out_free = !res_valid_s2 || !result_stall;
	assign s1_go    = valid_s1 && (!flags_s1.emit || out_free);
	assign s1_free  = !valid_s1 || s1_go;
	assign pop      = q_valid && s1_free;

	// Bank addresses: banks split by column parity, so the center and up
	// reads share one bank and the left and right reads share the other.
	always_comb begin
		lcol  = q_col - COL_W'(1);
		rcol  = q_col + COL_W'(1);
		caddr = {q_flags.cpar, q_col[COL_W-1:1]};
		uaddr = {q_flags.upar, q_col[COL_W-1:1]};
		laddr = {q_flags.cpar, lcol[COL_W-1:1]};
		raddr = {q_flags.cpar, rcol[COL_W-1:1]};
		waddr = {~q_flags.cpar, q_col[COL_W-1:1]};
		addr_a[0] = q_col[0] ? laddr : caddr;
		addr_a[1] = q_col[0] ? caddr : laddr;
		addr_b[0] = q_col[0] ? raddr : uaddr;
		addr_b[1] = q_col[0] ? uaddr : raddr;
		we[0] = pop && q_flags.write && !q_col[0];
		we[1] = pop && q_flags.write && q_col[0];
	end

	// Row store banks: two reads and one write per cycle, reads see old data
	for (genvar b = 0; b < 2; b++) begin : g_bank
		logic mem [BANK_DEPTH];

		always_ff @(posedge clk) begin
			if (pop) begin
				rda_s1[b] <= mem[addr_a[b]];
				rdb_s1[b] <= mem[addr_b[b]];
			end
			if (we[b]) begin
				mem[waddr] <= q_flags.pix;
			end
		end
	end

	// Command registers of the read stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_free) begin
			valid_s1 <= pop;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			flags_s1 <= q_flags;
			col0_s1  <= q_col[0];
		end
	end

	// Window assembly with edge clamping
	always_comb begin
		w_c    = col0_s1 ? rda_s1[1] : rda_s1[0];
		w_l    = flags_s1.l_use_c ? w_c : (col0_s1 ? rda_s1[0] : rda_s1[1]);
		w_r    = flags_s1.r_use_c ? w_c : (col0_s1 ? rdb_s1[0] : rdb_s1[1]);
		w_up   = flags_s1.up_is_c ? w_c : (col0_s1 ? rdb_s1[1] : rdb_s1[0]);
		w_down = flags_s1.down_is_c ? w_c : flags_s1.pix;
	end

	// Morphology operator
	always_comb begin
		unique case (mode)
			MODE_ERODE: begin
				w_res = w_up & w_l & w_c & w_r & w_down;
			end
			MODE_DILATE: begin
				w_res = w_up | w_l | w_c | w_r | w_down;
			end
			MODE_DESPECKLE: begin
				w_res = w_c & (w_up | w_l | w_r | w_down);
			end
			MODE_HOLE_FILL: begin
				w_res = w_c | (w_up & w_l & w_r & w_down);
			end
			default: begin
				w_res = 1'b0;
			end
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (s1_go && flags_s1.emit) begin
			res_valid_s2 <= 1'b1;
		end else if (!result_stall) begin
			res_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && flags_s1.emit) begin
			res_s2.result_pixel <= w_res;
			res_s2.frame_end    <= flags_s1.frame_end;
		end
	end

	assign result_valid = res_valid_s2;
	assign result       = res_s2;

endmodule

// ----- sv/binary_cross_morphology_top.sv -----
// Top level: configuration registers and the front, queue and back of the morphology block.
//
// Binary 3x3 cross (plus) morphology on a raster pixel stream: erosion, dilation,
// isolated pixel removal or hole fill, chosen by the mode register, with edge
// pixels replicated outside the frame. Results trail the input by one row; after
// the last pixel of a frame, one flush item per column drains the final row and
// the last result carries frame_end. Pixel items that arrive while the last row
// drains are dropped, as are flush items with nothing to drain. The block
// sustains one item per clock while the result port does not stall: the row
// store is split by column parity into two banks, each with two read ports and
// one write port, so the four window reads and the pixel write of one item all
// happen in the same cycle. An accepted item's command passes through the
// queue, the read stage and the output register before its result reaches the
// result port; a four-entry command queue sits between the front end and the
// row store so either side can stall on its own. The configuration port is
// always ready; registers must only be written while no item is in flight.
module binary_cross_morphology_top #(
	parameter int unsigned MAX_WIDTH = bcm_pkg::MAX_WIDTH_DEFAULT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	output logic                                item_stall,
	input  bcm_pkg::item_t                      item,
	output logic                                result_valid,
	input  logic                                result_stall,
	output bcm_pkg::result_t                    result,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [bcm_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [bcm_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import bcm_pkg::*;

	localparam int unsigned COL_W = $clog2(MAX_WIDTH);

	morph_mode_t               mode_q;
	logic [FRAME_WIDTH_W-1:0]  width_q;
	logic [FRAME_HEIGHT_W-1:0] height_q;

	logic             push;
	cmd_flags_t       push_flags;
	logic [COL_W-1:0] push_col;
	logic             pop;
	cmd_flags_t       head_flags;
	logic [COL_W-1:0] head_col;
	logic             q_not_empty;
	logic             q_full;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_ERODE;
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_MODE: begin
					mode_q <= morph_mode_t'(cfg_data[1:0]);
				end
				CFG_WIDTH: begin
					width_q <= cfg_data[FRAME_WIDTH_W-1:0];
				end
				CFG_HEIGHT: begin
					height_q <= cfg_data[FRAME_HEIGHT_W-1:0];
				end
				default: begin
					mode_q <= mode_q;
				end
			endcase
		end
	end

	assign item_stall = q_full;

	bcm_front #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item         (item),
		.frame_width  (width_q),
		.frame_height (height_q),
		.q_full       (q_full),
		.push         (push),
		.push_flags   (push_flags),
		.push_col     (push_col)
	);

	bcm_queue #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_flags (push_flags),
		.push_col   (push_col),
		.pop        (pop),
		.head_flags (head_flags),
		.head_col   (head_col),
		.not_empty  (q_not_empty),
		.full       (q_full)
	);

	bcm_back #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.mode         (mode_q),
		.q_valid      (q_not_empty),
		.q_flags      (head_flags),
		.q_col        (head_col),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule
